### rtl/lrm_pkg.sv
// Shared types, constants and sine table for the lidar ray-march block.
package lrm_pkg;

    localparam int MAX_WALLS    = 32;
    localparam int WALL_BITS    = $clog2(MAX_WALLS);
    localparam int MAX_RAYS     = 64;
    localparam int RAY_BITS     = 6;
    localparam int COORD_BITS   = 16;
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
    localparam int PT_BITS      = 18;   // point and box bound width, never wraps

    localparam logic [7:0] WALL_KIND = 8'd2;
    localparam logic       FUNC_LOAD = 1'b0;
    localparam logic       FUNC_SCAN = 1'b1;

    // register indexes on the config port
    localparam logic [2:0] REG_FOV    = 3'd0;
    localparam logic [2:0] REG_RAYS   = 3'd1;
    localparam logic [2:0] REG_START  = 3'd2;
    localparam logic [2:0] REG_LIMIT  = 3'd3;
    localparam logic [2:0] REG_STEP   = 3'd4;
    localparam logic [2:0] REG_WIDTH  = 3'd5;
    localparam logic [2:0] REG_HEIGHT = 3'd6;
    localparam logic [2:0] REG_WALLS  = 3'd7;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] bottom;
        logic [14:0]                  ext_x;
        logic [14:0]                  ext_y;
    } t_box;

    typedef struct packed {
        logic [15:0] fov;
        logic [6:0]  rays;
        logic [14:0] start;
        logic [14:0] limit;
        logic [14:0] step;
        logic [14:0] width;
        logic [14:0] height;
        logic [5:0]  walls;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_LUT, S_CHK, S_MUL, S_PT, S_WALL, S_ADV
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic div_step;
        logic lut;
        logic mul;
        logic point;
        logic wall_step;
        logic adv;
        logic emit_hit;
        logic emit_lim;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic dist_ge_limit;
        logic hit;
        logic wall_end;
        logic last_ray;
    } t_sts;

    typedef logic [SINE_ENTRIES-1:0][15:0] t_sine_tab;

    // Q1.14 sine over a full turn, quarter-wave polynomial
    function automatic t_sine_tab f_sine_tab();
        t_sine_tab tab;
        longint a, q, r, x, x2, inner, mid, y;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            a     = (longint'(k) * 65536) / SINE_ENTRIES;
            q     = (a >> 14) & 3;
            r     = a & 16383;
            x     = ((q & 1) != 0) ? (16384 - r) : r;
            x2    = (x * x) >> 14;
            inner = 10512 - ((x2 * 1160) >> 14);
            mid   = 25736 - ((x2 * inner) >> 14);
            y     = (x * mid) >> 14;
            if (q >= 2) begin
                y = -y;
            end
            tab[k] = y[15:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = f_sine_tab();

endpackage

### rtl/lrm_ctrl.sv
// Sequencer for scan setup, per-ray marching and wall sweep.
module lrm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_func,
    input  lrm_pkg::t_sts i_sts,
    output lrm_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import lrm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_func == FUNC_SCAN) n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_last) n_state = S_LUT;
            end
            S_LUT: n_state = S_CHK;
            S_CHK: begin
                if (i_sts.dist_ge_limit) n_state = i_sts.last_ray ? S_IDLE : S_LUT;
                else n_state = S_MUL;
            end
            S_MUL: n_state = S_PT;
            S_PT:  n_state = S_WALL;
            S_WALL: begin
                if (i_sts.hit) n_state = i_sts.last_ray ? S_IDLE : S_LUT;
                else if (i_sts.wall_end) n_state = S_ADV;
            end
            S_ADV: n_state = S_CHK;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy          = 1'b0;
                o_cmd.load      = i_start && i_func == FUNC_LOAD;
                o_cmd.scan_init = i_start && i_func == FUNC_SCAN;
            end
            S_DIV:  o_cmd.div_step = 1'b1;
            S_LUT:  o_cmd.lut = 1'b1;
            S_CHK:  o_cmd.emit_lim = i_sts.dist_ge_limit;
            S_MUL:  o_cmd.mul = 1'b1;
            S_PT:   o_cmd.point = 1'b1;
            S_WALL: begin
                o_cmd.emit_hit  = i_sts.hit;
                o_cmd.wall_step = !i_sts.hit && !i_sts.wall_end;
            end
            S_ADV:  o_cmd.adv = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    a_emit_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_hit || o_cmd.emit_lim) |-> (r_state == S_CHK || r_state == S_WALL))
        else $error("result issued outside a decision state");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((o_cmd.emit_hit || o_cmd.emit_lim) && i_sts.last_ray) |=> r_state == S_IDLE)
        else $error("scan did not end after its last ray");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_busy)
        else $error("wall load while scanning");

endmodule

### rtl/lrm_dp.sv
// Datapath: wall store, step divider, sine lookup, point math and wall tests.
module lrm_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lrm_pkg::t_cmd                       i_cmd,
    input  lrm_pkg::t_cfg                       i_cfg,
    input  logic [lrm_pkg::WALL_BITS-1:0]       i_wall_slot,
    input  logic [7:0]                          i_wall_kind,
    input  logic signed [lrm_pkg::COORD_BITS-1:0] i_wall_left,
    input  logic signed [lrm_pkg::COORD_BITS-1:0] i_wall_bottom,
    input  logic [14:0]                         i_wall_extent_x,
    input  logic [14:0]                         i_wall_extent_y,
    input  logic signed [lrm_pkg::COORD_BITS-1:0] i_pose_x,
    input  logic signed [lrm_pkg::COORD_BITS-1:0] i_pose_y,
    input  logic [15:0]                         i_pose_heading,
    output lrm_pkg::t_sts                       o_sts,
    output logic                                o_valid,
    output logic [lrm_pkg::RAY_BITS-1:0]        o_ray_number,
    output logic [14:0]                         o_hit_range,
    output logic                                o_last_ray
);
    import lrm_pkg::*;

    t_box                   r_mem [MAX_WALLS];
    t_box                   r_rd;
    logic [MAX_WALLS-1:0]   r_valid;

    logic signed [COORD_BITS-1:0] r_ox, r_oy;
    logic [15:0]            r_angle;
    logic [5:0]             r_rem;
    logic [15:0]            r_quo;
    logic [3:0]             r_dcnt;
    logic [RAY_BITS-1:0]    r_ray;
    logic signed [15:0]     r_cos, r_sin;
    logic [15:0]            r_dist;
    logic signed [31:0]     r_pc, r_ps;
    logic signed [PT_BITS-1:0] r_px, r_py;
    logic                   r_oob;
    logic [WALL_BITS:0]     r_widx, n_widx;

    logic [6:0]             rays_eff;
    logic [5:0]             divisor;
    logic [6:0]             trial;
    logic                   qbit;
    logic [15:0]            ray_step;
    logic [14:0]            march_step;
    logic [WALL_BITS:0]     walls_eff;
    logic [15:0]            cos_angle;
    logic signed [PT_BITS-1:0] px, py, lo_x, hi_x, lo_y, hi_y;
    logic                   in_box;

    always_comb begin
        if (i_cfg.rays == 7'd0) rays_eff = 7'd1;
        else if (i_cfg.rays > 7'(MAX_RAYS)) rays_eff = 7'(MAX_RAYS);
        else rays_eff = i_cfg.rays;
        divisor    = 6'(rays_eff - 7'd1);
        trial      = {r_rem, r_quo[15]};
        qbit       = trial >= {1'b0, divisor};
        ray_step   = (rays_eff == 7'd1) ? 16'd0 : r_quo;
        march_step = (i_cfg.step == 15'd0) ? 15'd1 : i_cfg.step;
        walls_eff  = (i_cfg.walls > 6'(MAX_WALLS)) ? (WALL_BITS+1)'(MAX_WALLS)
                                                  : (WALL_BITS+1)'(i_cfg.walls);
        cos_angle  = r_angle + 16'd16384;
        px = PT_BITS'(r_ox) + PT_BITS'(r_pc >>> 14);
        py = PT_BITS'(r_oy) + PT_BITS'(r_ps >>> 14);
        lo_x = PT_BITS'(r_rd.left);
        hi_x = lo_x + PT_BITS'({1'b0, r_rd.ext_x});
        lo_y = PT_BITS'(r_rd.bottom);
        hi_y = lo_y + PT_BITS'({1'b0, r_rd.ext_y});
        in_box = r_px >= lo_x && r_px <= hi_x && r_py >= lo_y && r_py <= hi_y;
        if (i_cmd.point) n_widx = '0;
        else if (i_cmd.wall_step) n_widx = r_widx + 1'b1;
        else n_widx = r_widx;
    end

    assign o_sts.div_last      = r_dcnt == 4'd15;
    assign o_sts.dist_ge_limit = r_dist >= {1'b0, i_cfg.limit};
    assign o_sts.wall_end      = r_widx >= walls_eff;
    assign o_sts.hit           = r_oob || (!o_sts.wall_end && r_valid[r_widx[WALL_BITS-1:0]]
                                           && in_box);
    assign o_sts.last_ray      = ({1'b0, r_ray} + 7'd1) == rays_eff;

    // wall store, read address follows the sweep index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[i_wall_slot] <= '{i_wall_left, i_wall_bottom, i_wall_extent_x,
                                    i_wall_extent_y};
        end
        r_rd <= r_mem[n_widx[WALL_BITS-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.load) begin
            r_valid[i_wall_slot] <= i_wall_kind == WALL_KIND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit_hit || i_cmd.emit_lim;
        end
    end

    always_ff @(posedge i_clk) begin
        r_widx <= n_widx;
        if (i_cmd.scan_init) begin
            r_ox    <= i_pose_x;
            r_oy    <= i_pose_y;
            r_angle <= i_pose_heading - {1'b0, i_cfg.fov[15:1]};
            r_rem   <= '0;
            r_quo   <= i_cfg.fov;
            r_dcnt  <= '0;
            r_ray   <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= qbit ? 6'(trial - {1'b0, divisor}) : trial[5:0];
            r_quo  <= {r_quo[14:0], qbit};
            r_dcnt <= r_dcnt + 4'd1;
        end
        if (i_cmd.lut) begin
            r_sin  <= SINE_TAB[r_angle[15 -: SINE_BITS]];
            r_cos  <= SINE_TAB[cos_angle[15 -: SINE_BITS]];
            r_dist <= {1'b0, i_cfg.start};
        end
        if (i_cmd.mul) begin
            r_pc <= $signed({1'b0, r_dist[14:0]}) * r_cos;
            r_ps <= $signed({1'b0, r_dist[14:0]}) * r_sin;
        end
        if (i_cmd.point) begin
            r_px  <= px;
            r_py  <= py;
            r_oob <= px < 0 || py < 0 || px > PT_BITS'({1'b0, i_cfg.width})
                     || py > PT_BITS'({1'b0, i_cfg.height});
        end
        if (i_cmd.adv) begin
            r_dist <= r_dist + {1'b0, march_step};
        end
        if (i_cmd.emit_hit || i_cmd.emit_lim) begin
            o_ray_number <= r_ray;
            o_hit_range  <= i_cmd.emit_hit ? r_dist[14:0] : i_cfg.limit;
            o_last_ray   <= o_sts.last_ray;
            r_ray        <= r_ray + 1'b1;
            r_angle      <= r_angle + ray_step;
        end
    end

endmodule

### rtl/lidar_ray_march_aabb.sv
// Top level: config registers, sequencer and datapath of the lidar ray marcher.
//
// A load transaction (func 0) writes one wall slot in the cycle it is taken and
// produces no result; busy stays low. A scan transaction (func 1) raises busy
// and emits one range per ray on o_valid, one cycle each; the receiver cannot
// stall, so results leave as soon as they are found. A scan first runs the
// angle-step divider, then per ray a sine lookup and, for each march point, a
// limit check, multiply, point step and a sweep of the wall slots (one slot per
// cycle through the registered wall store read port). A ray ends at the first
// hit point, at leaving the world box, or at range_limit. Config registers sit
// on the APB port at byte address 4*index and must only be written while idle.
module lidar_ray_march_aabb (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic                                i_func,
    input  logic [4:0]                          i_wall_slot,
    input  logic [7:0]                          i_wall_kind,
    input  logic signed [lrm_pkg::COORD_BITS-1:0] i_wall_left,
    input  logic signed [lrm_pkg::COORD_BITS-1:0] i_wall_bottom,
    input  logic [14:0]                         i_wall_extent_x,
    input  logic [14:0]                         i_wall_extent_y,
    input  logic signed [lrm_pkg::COORD_BITS-1:0] i_pose_x,
    input  logic signed [lrm_pkg::COORD_BITS-1:0] i_pose_y,
    input  logic [15:0]                         i_pose_heading,
    output logic                                o_valid,
    output logic [5:0]                          o_ray_number,
    output logic [14:0]                         o_hit_range,
    output logic                                o_last_ray,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import lrm_pkg::*;

    t_cfg       r_cfg;
    t_cmd       cmd;
    t_sts       sts;
    logic       cfg_wr;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    // config registers, values masked to their widths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{fov: 16'd32768, rays: 7'd64, start: 15'd0, limit: 15'd2560,
                       step: 15'd13, width: 15'd2560, height: 15'd2560, walls: 6'd0};
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_FOV:    r_cfg.fov    <= pwdata[15:0];
                REG_RAYS:   r_cfg.rays   <= pwdata[6:0];
                REG_START:  r_cfg.start  <= pwdata[14:0];
                REG_LIMIT:  r_cfg.limit  <= pwdata[14:0];
                REG_STEP:   r_cfg.step   <= pwdata[14:0];
                REG_WIDTH:  r_cfg.width  <= pwdata[14:0];
                REG_HEIGHT: r_cfg.height <= pwdata[14:0];
                REG_WALLS:  r_cfg.walls  <= pwdata[5:0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FOV:    prdata = {16'd0, r_cfg.fov};
            REG_RAYS:   prdata = {25'd0, r_cfg.rays};
            REG_START:  prdata = {17'd0, r_cfg.start};
            REG_LIMIT:  prdata = {17'd0, r_cfg.limit};
            REG_STEP:   prdata = {17'd0, r_cfg.step};
            REG_WIDTH:  prdata = {17'd0, r_cfg.width};
            REG_HEIGHT: prdata = {17'd0, r_cfg.height};
            REG_WALLS:  prdata = {26'd0, r_cfg.walls};
            default:    prdata = '0;
        endcase
    end

    lrm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    lrm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg           (r_cfg),
        .i_wall_slot     (i_wall_slot),
        .i_wall_kind     (i_wall_kind),
        .i_wall_left     (i_wall_left),
        .i_wall_bottom   (i_wall_bottom),
        .i_wall_extent_x (i_wall_extent_x),
        .i_wall_extent_y (i_wall_extent_y),
        .i_pose_x        (i_pose_x),
        .i_pose_y        (i_pose_y),
        .i_pose_heading  (i_pose_heading),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_ray_number    (o_ray_number),
        .o_hit_range     (o_hit_range),
        .o_last_ray      (o_last_ray)
    );

endmodule
